FILE: rtl/psa_pkg.sv
// shared types and constants for the premultiplied saturation adjust block
// no dependencies; used by the channel interfaces and the top level
package psa_pkg;

	localparam int unsigned CH_W = 8;

	// percent range of the saturation register
	localparam logic signed [7:0] PCT_MAX = 8'sd100;
	localparam logic signed [7:0] PCT_MIN = -8'sd100;

	// 32 * round_up(65536 / 25): percent * 128 / 100 as multiply and shift
	localparam logic [23:0] PCT_SCALE = 24'd83904;

	typedef struct packed {
		logic [CH_W-1:0] blue_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] alpha_in;
	} pix_in_t;

	typedef struct packed {
		logic [CH_W-1:0] blue_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] alpha_out;
	} pix_out_t;

endpackage

FILE: rtl/psa_if.sv
// valid/ready pixel channels for the input and result sides
// depends on psa_pkg
interface psa_in_if;
	import psa_pkg::*;
	logic    valid;
	logic    ready;
	pix_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface psa_out_if;
	import psa_pkg::*;
	logic     valid;
	logic     ready;
	pix_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/psa_div.sv
// pipelined restoring divider, BPS quotient bits per stage, shared divisor
// across LN lanes, with a sideband word carried alongside; no dependencies
module psa_div #(
	parameter int LN  = 1,
	parameter int NW  = 16,
	parameter int DW  = 8,
	parameter int QW  = 8,
	parameter int BPS = 4,
	parameter int SW  = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [LN-1:0][NW-1:0]  num,
	input  logic [DW-1:0]          den,
	input  logic [SW-1:0]          side_in,
	output logic                   out_valid,
	output logic [LN-1:0][QW-1:0]  quo,
	output logic [SW-1:0]          side_out
);

	localparam int STG = (QW + BPS - 1) / BPS;
	localparam int QP  = STG * BPS;
	localparam int XW  = QP + DW;

	logic                  vld_s  [STG+1];
	logic [DW-1:0]         den_s  [STG+1];
	logic [SW-1:0]         side_s [STG+1];
	logic [LN-1:0][DW-1:0] rem_s  [STG+1];
	logic [LN-1:0][QP-1:0] low_s  [STG+1];
	logic [LN-1:0][QP-1:0] quo_s  [STG+1];

	// the quotient fits QW bits, so the top part of the numerator is below den
	always_comb begin
		logic [XW-1:0] nx;
		vld_s[0]  = in_valid;
		den_s[0]  = den;
		side_s[0] = side_in;
		for (int i = 0; i < LN; i++) begin
			nx = XW'(num[i]);
			rem_s[0][i] = nx[XW-1:QP];
			low_s[0][i] = nx[QP-1:0];
			quo_s[0][i] = '0;
		end
	end

	for (genvar k = 0; k < STG; k++) begin : g_stage
		logic [LN-1:0][DW-1:0] nrem;
		logic [LN-1:0][QP-1:0] nlow;
		logic [LN-1:0][QP-1:0] nquo;

		always_comb begin
			logic [DW:0]   tr;
			logic [DW-1:0] r;
			logic [QP-1:0] lo;
			logic [QP-1:0] q;
			for (int i = 0; i < LN; i++) begin
				r  = rem_s[k][i];
				lo = low_s[k][i];
				q  = quo_s[k][i];
				for (int j = 0; j < BPS; j++) begin
					tr = {r, lo[QP-1]};
					lo = {lo[QP-2:0], 1'b0};
					if (tr >= {1'b0, den_s[k]}) begin
						r = DW'(tr - {1'b0, den_s[k]});
						q = {q[QP-2:0], 1'b1};
					end else begin
						r = tr[DW-1:0];
						q = {q[QP-2:0], 1'b0};
					end
				end
				nrem[i] = r;
				nlow[i] = lo;
				nquo[i] = q;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
				rem_s[k+1]  <= nrem;
				low_s[k+1]  <= nlow;
				quo_s[k+1]  <= nquo;
			end
		end
	end

	assign out_valid = vld_s[STG];
	assign side_out  = side_s[STG];

	always_comb begin
		for (int i = 0; i < LN; i++) begin
			quo[i] = quo_s[STG][i][QW-1:0];
		end
	end

endmodule

FILE: rtl/premultiplied_saturation_adjust.sv
// saturation adjust of premultiplied bgra pixels, one pixel per beat
// one pixel per cycle sustained while the output is not stalled;
// the three dividers (un-premultiply, saturation, gain reciprocal) take 2, 2 and 4 stages
// a stalled output holds the whole pipeline; input ready follows output ready
// reset clears the valid bits and sets the saturation change to zero
// depends on psa_pkg, psa_if and psa_div
module premultiplied_saturation_adjust (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wen,
	input  logic signed [7:0]        cfg_wdata,
	psa_in_if.sink                   pix_in,
	psa_out_if.source                pix_out
);
	import psa_pkg::*;

	typedef struct packed {
		logic [2:0][CH_W-1:0] cp;
		logic [CH_W-1:0]      l;
		pix_in_t              raw;
		logic                 pass;
	} b_side_t;

	typedef struct packed {
		logic [2:0][CH_W-1:0] cp;
		logic [CH_W-1:0]      l;
		pix_in_t              raw;
		logic                 pass;
		logic                 vneg;
		logic signed [8:0]    v;
		logic                 tzero;
	} c_side_t;

	logic en;
	assign en = !pix_out.valid || pix_out.ready;
	assign pix_in.ready = en;

	// saturation register held already scaled to -128..128
	logic signed [8:0] v_q;
	logic signed [8:0] v_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (cfg_wen) begin
			v_q <= v_next;
		end
	end

	always_comb begin
		logic signed [7:0] pct;
		logic [6:0]        mag;
		logic [23:0]       scaled;
		pct = cfg_wdata;
		if (pct > PCT_MAX) pct = PCT_MAX;
		if (pct < PCT_MIN) pct = PCT_MIN;
		mag    = pct[7] ? 7'(-pct) : pct[6:0];
		scaled = 24'(mag) * PCT_SCALE;
		v_next = pct[7] ? -$signed({1'b0, scaled[23:16]}) : $signed({1'b0, scaled[23:16]});
	end

	// un-premultiply: clamp to alpha then c*255/alpha
	logic [2:0][15:0] num_a;
	always_comb begin
		logic [7:0] ch [3];
		ch[0] = pix_in.data.blue_in;
		ch[1] = pix_in.data.green_in;
		ch[2] = pix_in.data.red_in;
		for (int i = 0; i < 3; i++) begin
			if (ch[i] > pix_in.data.alpha_in) ch[i] = pix_in.data.alpha_in;
			num_a[i] = {ch[i], 8'b0} - {8'b0, ch[i]};
		end
	end

	logic             vld_a;
	logic [2:0][7:0]  cp_a;
	pix_in_t          raw_a;

	psa_div #(.LN(3), .NW(16), .DW(8), .QW(8), .BPS(4), .SW($bits(pix_in_t))) u_div_unpm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pix_in.valid),
		.num       (num_a),
		.den       (pix_in.data.alpha_in),
		.side_in   (pix_in.data),
		.out_valid (vld_a),
		.quo       (cp_a),
		.side_out  (raw_a)
	);

	// min, max, lightness and the saturation divisor
	logic       vld_s1;
	b_side_t    bs_s1;
	logic [7:0] d_s1;
	logic [8:0] den_s1;

	logic [7:0] mn_c, mx_c;
	logic [8:0] sum_c;
	always_comb begin
		mn_c = cp_a[0];
		mx_c = cp_a[0];
		for (int i = 1; i < 3; i++) begin
			if (cp_a[i] < mn_c) mn_c = cp_a[i];
			if (cp_a[i] > mx_c) mx_c = cp_a[i];
		end
		sum_c = 9'(mx_c) + 9'(mn_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bs_s1.cp   <= cp_a;
			bs_s1.l    <= sum_c[8:1];
			bs_s1.raw  <= raw_a;
			bs_s1.pass <= (raw_a.alpha_in == '0) || (mx_c == mn_c);
			d_s1       <= mx_c - mn_c;
			den_s1     <= sum_c[8] ? 9'(9'd510 - sum_c) : sum_c;
		end
	end

	logic       vld_b;
	logic [7:0] sv_b;
	b_side_t    bs_b;

	psa_div #(.LN(1), .NW(15), .DW(9), .QW(8), .BPS(4), .SW($bits(b_side_t))) u_div_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.num       ({d_s1, 7'b0}),
		.den       (den_s1),
		.side_in   (bs_s1),
		.out_valid (vld_b),
		.quo       (sv_b),
		.side_out  (bs_b)
	);

	// reciprocal divisor for the gain
	logic       vld_s2;
	c_side_t    cs_s2;
	logic [7:0] t_s2;

	logic [7:0] t_c;
	always_comb begin
		logic [8:0] vs;
		vs  = 9'(v_q[7:0]) + 9'(sv_b);
		t_c = (vs >= 9'd128) ? sv_b : 8'(9'd128 - 9'(v_q[7:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_b;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s2.cp    <= bs_b.cp;
			cs_s2.l     <= bs_b.l;
			cs_s2.raw   <= bs_b.raw;
			cs_s2.pass  <= bs_b.pass;
			cs_s2.vneg  <= v_q[8];
			cs_s2.v     <= v_q;
			cs_s2.tzero <= (t_c == '0);
			t_s2        <= t_c;
		end
	end

	logic        vld_c;
	logic [14:0] rq_c;
	c_side_t     cs_c;

	psa_div #(.LN(1), .NW(15), .DW(8), .QW(15), .BPS(4), .SW($bits(c_side_t))) u_div_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.num       (15'd16384),
		.den       (t_s2),
		.side_in   (cs_s2),
		.out_valid (vld_c),
		.quo       (rq_c),
		.side_out  (cs_c)
	);

	// gain times distance from lightness
	logic                    vld_s3;
	logic signed [24:0]      prod_s3 [3];
	logic [2:0][7:0]         cp_s3;
	pix_in_t                 raw_s3;
	logic                    pass_s3;

	logic signed [15:0] g_c;
	logic signed [24:0] prod_c [3];
	always_comb begin
		logic signed [8:0] diff;
		if (cs_c.vneg) begin
			g_c = 16'(cs_c.v);
		end else if (cs_c.tzero) begin
			g_c = '0;
		end else begin
			g_c = $signed(16'(rq_c) - 16'd128);
		end
		for (int i = 0; i < 3; i++) begin
			diff      = $signed({1'b0, cs_c.cp[i]}) - $signed({1'b0, cs_c.l});
			prod_c[i] = diff * g_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= prod_c;
			cp_s3   <= cs_c.cp;
			raw_s3  <= cs_c.raw;
			pass_s3 <= cs_c.pass;
		end
	end

	// new channel value, then scale back by alpha
	logic               vld_s4;
	logic signed [27:0] xa_s4 [3];
	logic [2:0]         npos_s4;
	pix_in_t            raw_s4;
	logic               pass_s4;

	logic signed [27:0] xa_c [3];
	logic [2:0]         npos_c;
	always_comb begin
		logic signed [18:0] x;
		for (int i = 0; i < 3; i++) begin
			x         = $signed({11'b0, cp_s3[i]}) + 19'(prod_s3[i] >>> 7);
			npos_c[i] = (x <= 0);
			xa_c[i]   = x * $signed({1'b0, raw_s3.alpha_in});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xa_s4   <= xa_c;
			npos_s4 <= npos_c;
			raw_s4  <= raw_s3;
			pass_s4 <= pass_s3;
		end
	end

	// rounded divide by 255 and clamp, or the pixel as it came in
	logic [7:0] ch_c [3];
	always_comb begin
		logic [27:0] y;
		logic [16:0] y17;
		logic [7:0]  rawc [3];
		rawc[0] = raw_s4.blue_in;
		rawc[1] = raw_s4.green_in;
		rawc[2] = raw_s4.red_in;
		for (int i = 0; i < 3; i++) begin
			y   = 28'(xa_s4[i]) + 28'd127;
			y17 = 17'(y[15:0]) + 17'(y[15:8]) + 17'd1;
			if (pass_s4) begin
				ch_c[i] = rawc[i];
			end else if (npos_s4[i]) begin
				ch_c[i] = '0;
			end else if (y >= 28'd65280) begin
				ch_c[i] = 8'd255;
			end else begin
				ch_c[i] = y17[15:8];
			end
		end
	end

	logic     vld_s5;
	pix_out_t out_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s5.blue_out  <= ch_c[0];
			out_s5.green_out <= ch_c[1];
			out_s5.red_out   <= ch_c[2];
			out_s5.alpha_out <= raw_s4.alpha_in;
		end
	end

	assign pix_out.valid = vld_s5;
	assign pix_out.data  = out_s5;

endmodule

FILE: dv/psa_checker.sv
// checker for the saturation adjust block: watches both pixel channels,
// predicts each result pixel and compares it; depends on psa_pkg
`timescale 1ns / 100ps
module psa_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic signed [7:0] cfg_wdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  psa_pkg::pix_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  psa_pkg::pix_out_t out_data,
	output int                fail_count,
	output int                pending
);
	import psa_pkg::*;

	logic signed [7:0] sat_pct;
	pix_out_t          expected_pixels[$];

	function automatic int floor_by_128(int p);
		if (p >= 0) return p / 128;
		return -((-p + 127) / 128);
	endfunction

	function automatic logic [7:0] repremul(int x, int a);
		int q;
		if (x <= 0) return 8'd0;
		q = (x * a + 127) / 255;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	function automatic pix_out_t adjust_pixel(pix_in_t p, logic signed [7:0] pct_reg);
		pix_out_t r;
		int a, mn, mx, d, s, l, den, sv, pct, v, t, g;
		int c[3];
		int raw[3];
		r = {p.blue_in, p.green_in, p.red_in, p.alpha_in};
		a = p.alpha_in;
		if (a == 0) return r;
		raw[0] = p.blue_in; raw[1] = p.green_in; raw[2] = p.red_in;
		for (int i = 0; i < 3; i++) begin
			if (raw[i] > a) raw[i] = a;
			c[i] = raw[i] * 255 / a;
		end
		mn = c[0]; mx = c[0];
		for (int i = 1; i < 3; i++) begin
			if (c[i] < mn) mn = c[i];
			if (c[i] > mx) mx = c[i];
		end
		d = mx - mn;
		s = mx + mn;
		if (d == 0) return r;
		l = s >>> 1;
		den = (l < 128) ? s : (510 - s);
		sv = (den > 0) ? (d * 128) / den : 0;
		pct = pct_reg;
		if (pct > 100) pct = 100;
		if (pct < -100) pct = -100;
		v = pct * 128 / 100;
		if (v >= 0) begin
			t = (v + sv >= 128) ? sv : 128 - v;
			g = (t != 0) ? (16384 / t - 128) : 0;
		end else begin
			g = v;
		end
		r.blue_out  = repremul(c[0] + floor_by_128((c[0] - l) * g), a);
		r.green_out = repremul(c[1] + floor_by_128((c[1] - l) * g), a);
		r.red_out   = repremul(c[2] + floor_by_128((c[2] - l) * g), a);
		return r;
	endfunction

	assign pending = expected_pixels.size();

	always @(posedge clk or negedge arst_n) begin
		pix_out_t e;
		if (!arst_n) begin
			sat_pct <= '0;
			fail_count <= 0;
			expected_pixels.delete();
		end else begin
			if (cfg_wen) sat_pct <= cfg_wdata;
			if (in_valid && in_ready)
				expected_pixels.push_back(adjust_pixel(in_data, sat_pct));
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					$error("result beat with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_pixels.pop_front();
					if (e != out_data) begin
						fail_count <= fail_count + 1;
						if (e.blue_out != out_data.blue_out)
							$error("blue_out exp %0d got %0d", e.blue_out, out_data.blue_out);
						if (e.green_out != out_data.green_out)
							$error("green_out exp %0d got %0d", e.green_out, out_data.green_out);
						if (e.red_out != out_data.red_out)
							$error("red_out exp %0d got %0d", e.red_out, out_data.red_out);
						if (e.alpha_out != out_data.alpha_out)
							$error("alpha_out exp %0d got %0d", e.alpha_out, out_data.alpha_out);
					end
				end
			end
		end
	end
endmodule

FILE: dv/tb_premultiplied_saturation_adjust.sv
// stimulus and verdict for the saturation adjust block
// depends on psa_pkg, psa_if, the block and psa_checker
`timescale 1ns / 100ps
module tb_premultiplied_saturation_adjust;
	import psa_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wen = 1'b0;
	logic signed [7:0] cfg_wdata = '0;
	logic              calm = 1'b0;
	logic              done = 1'b0;
	int                fail_count;
	int                pending;
	int                idle_cycles = 0;

	psa_in_if  pix_in ();
	psa_out_if pix_out ();

	premultiplied_saturation_adjust i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.pix_in   (pix_in.sink),
		.pix_out  (pix_out.source)
	);

	psa_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.in_data   (pix_in.data),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.out_data  (pix_out.data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always #1 clk = ~clk;

	initial begin
		pix_in.valid = 1'b0;
		pix_in.data = '0;
		pix_out.ready = 1'b0;
	end

	// result side stalls at random outside the calm stretch
	always @(posedge clk)
		pix_out.ready <= calm || ($urandom_range(99) >= 30);

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("premultiplied_saturation_adjust: mismatch");
			$finish;
		end
	end

	// valid stays high between back-to-back beats and drops only while idling
	task automatic send_pixel(pix_in_t p);
		if (!calm) begin
			while ($urandom_range(99) < 30) begin
				pix_in.valid <= 1'b0;
				@(posedge clk);
			end
		end
		pix_in.valid <= 1'b1;
		pix_in.data <= p;
		do @(posedge clk); while (!pix_in.ready);
	endtask

	task automatic drain;
		pix_in.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_percent(logic signed [7:0] pct);
		drain();
		cfg_wen <= 1'b1;
		cfg_wdata <= pct;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic pix_in_t random_pixel();
		pix_in_t p;
		int a;
		int mode;
		mode = $urandom_range(9);
		a = (mode == 0) ? 0 : (mode < 3) ? 255 : $urandom_range(255);
		p.alpha_in = 8'(a);
		if (mode == 9) begin
			p.blue_in = 8'($urandom);
			p.green_in = 8'($urandom);
			p.red_in = 8'($urandom);
		end else if (mode == 8) begin
			p.blue_in = 8'($urandom_range(a));
			p.green_in = p.blue_in;
			p.red_in = p.blue_in;
		end else begin
			p.blue_in = 8'($urandom_range(a));
			p.green_in = 8'($urandom_range(a));
			p.red_in = 8'($urandom_range(a));
		end
		return p;
	endfunction

	logic signed [7:0] pct_set[10] = '{8'sd0, 8'sd100, -8'sd100, 8'sd127, -8'sd128,
		8'sd50, -8'sd37, 8'sd1, -8'sd1, 8'sd99};
	pix_in_t directed[14] = '{
		{8'd0, 8'd0, 8'd0, 8'd0}, {8'd200, 8'd10, 8'd90, 8'd0},
		{8'd80, 8'd80, 8'd80, 8'd255}, {8'd40, 8'd40, 8'd40, 8'd128},
		{8'd255, 8'd0, 8'd0, 8'd255}, {8'd0, 8'd255, 8'd0, 8'd255},
		{8'd0, 8'd0, 8'd255, 8'd255}, {8'd255, 8'd255, 8'd0, 8'd255},
		{8'd255, 8'd10, 8'd0, 8'd100}, {8'd1, 8'd0, 8'd0, 8'd1},
		{8'd200, 8'd100, 8'd50, 8'd255}, {8'd250, 8'd240, 8'd230, 8'd255},
		{8'd5, 8'd15, 8'd10, 8'd20}, {8'd170, 8'd85, 8'd85, 8'd255}};

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed pixels at reset value, then at both extremes
		foreach (directed[i]) send_pixel(directed[i]);
		write_percent(8'sd100);
		foreach (directed[i]) send_pixel(directed[i]);
		write_percent(-8'sd100);
		foreach (directed[i]) send_pixel(directed[i]);
		for (int k = 0; k < 1700; k++) begin
			if (k % 170 == 0) write_percent(pct_set[k / 170]);
			calm <= (k >= 600 && k < 800);
			if (k % 100 == 50) write_percent(8'($urandom));
			send_pixel(random_pixel());
		end
		calm <= 1'b0;
		drain();
		if (fail_count == 0)
			$display("premultiplied_saturation_adjust: match");
		else
			$display("premultiplied_saturation_adjust: mismatch");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/psa_pkg.sv
rtl/psa_if.sv
rtl/psa_div.sv
rtl/premultiplied_saturation_adjust.sv
dv/psa_checker.sv
dv/tb_premultiplied_saturation_adjust.sv
